// File: rtl/core/utf8_to_utf16_decoder_defines.svh
// ---------------------------------------------------------------------------
// utf8_to_utf16_decoder_defines.svh
// Assertion macros shared by the UTF-8 to UTF-16 decoder RTL.
// ---------------------------------------------------------------------------
`ifndef UTF8_TO_UTF16_DECODER_DEFINES_SVH
`define UTF8_TO_UTF16_DECODER_DEFINES_SVH

// Check a property on every rising clk edge outside reset.
`define U8U16_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Check that an antecedent implies a consequent in the same cycle.
`define U8U16_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that an antecedent implies a consequent in the next cycle.
`define U8U16_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/u8u16_pkg.sv
// ---------------------------------------------------------------------------
// u8u16_pkg
// Types and constants shared by the UTF-8 to UTF-16 decoder modules.
// ---------------------------------------------------------------------------
package u8u16_pkg;

    // Byte class masks and patterns
    localparam logic [7:0] ASCII_MASK  = 8'b1000_0000;
    localparam logic [7:0] LEAD2_MASK  = 8'b1110_0000;
    localparam logic [7:0] LEAD2_PAT   = 8'b1100_0000;
    localparam logic [7:0] LEAD3_MASK  = 8'b1111_0000;
    localparam logic [7:0] LEAD3_PAT   = 8'b1110_0000;
    localparam logic [7:0] LEAD2_BITS  = 8'b0001_1111;
    localparam logic [7:0] CONT_BITS   = 8'b0011_1111;
    localparam logic [7:0] LEAD3_BITS  = 8'b0000_1111;

    // Continuation bytes still expected
    localparam logic [1:0] PEND_NONE = 2'd0;
    localparam logic [1:0] PEND_ONE  = 2'd1;
    localparam logic [1:0] PEND_TWO  = 2'd2;

    // One input transaction held in the input register
    typedef struct packed {
        logic [7:0] in_byte;
        logic       last_byte;
    } in_item_t;

    // One result transaction
    typedef struct packed {
        logic [15:0] code_unit;
        logic        unit_valid;
        logic        string_error;
        logic        end_of_string;
    } result_t;

endpackage

// File: rtl/core/u8u16_in_reg.sv
// ---------------------------------------------------------------------------
// u8u16_in_reg
// Input register: captures one byte transaction and holds it until the
// decode stage takes it.
// ---------------------------------------------------------------------------
module u8u16_in_reg
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  u8u16_pkg::in_item_t in_item,
    input  logic                take,
    output logic                held_valid,
    output u8u16_pkg::in_item_t held_item
);
    import u8u16_pkg::*;

    logic     valid_reg;
    logic     valid_next;
    in_item_t item_reg;

    // Accept when empty or when the held transaction leaves this cycle
    assign in_ready   = !valid_reg || take;
    assign valid_next = (in_valid && in_ready) ? 1'b1 : (take ? 1'b0 : valid_reg);

    // Hold the valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Load the payload on accept
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_item;
        end
    end

    assign held_valid = valid_reg;
    assign held_item  = item_reg;

endmodule

// File: rtl/core/u8u16_decode.sv
// ---------------------------------------------------------------------------
// u8u16_decode
// Decode stage: sequence state, one-byte decode logic and the result
// register that feeds the output channel.
// ---------------------------------------------------------------------------
`include "utf8_to_utf16_decoder_defines.svh"

module u8u16_decode
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                held_valid,
    input  u8u16_pkg::in_item_t held_item,
    output logic                take,
    output logic                out_valid,
    input  logic                out_ready,
    output u8u16_pkg::result_t  result
);
    import u8u16_pkg::*;

    logic [1:0] pend_reg;
    logic [1:0] pend_next;
    logic [9:0] part_reg;
    logic [9:0] part_next;
    logic       err_reg;
    logic       err_next;
    logic       res_valid_reg;
    logic       res_valid_next;
    result_t    res_reg;
    result_t    res_next;

    logic [1:0]  dec_pend;
    logic [9:0]  dec_part;
    logic        dec_err;
    logic        dec_done;
    logic [15:0] dec_unit;
    logic        emit;
    logic [7:0]  b;

    assign b = held_item.in_byte;

    // Take the held transaction when the result register can accept
    assign take = held_valid && (!res_valid_reg || out_ready);

    // Decode one byte against the current sequence state
    always_comb
    begin
        dec_pend = pend_reg;
        dec_part = part_reg;
        dec_err  = err_reg;
        dec_done = 1'b0;
        dec_unit = 16'd0;
        if (!err_reg)
        begin
            unique case (pend_reg)
                PEND_NONE:
                begin
                    if ((b & ASCII_MASK) == 8'd0)
                    begin
                        dec_unit = {8'd0, b};
                        dec_done = 1'b1;
                    end
                    else if ((b & LEAD2_MASK) == LEAD2_PAT)
                    begin
                        dec_part = {2'd0, b & LEAD2_BITS};
                        dec_pend = PEND_ONE;
                    end
                    else if ((b & LEAD3_MASK) == LEAD3_PAT)
                    begin
                        dec_part = {2'd0, b & LEAD3_BITS};
                        dec_pend = PEND_TWO;
                    end
                    else
                    begin
                        dec_err = 1'b1;
                    end
                end
                PEND_TWO:
                begin
                    dec_part = {part_reg[3:0], b[5:0]};
                    dec_pend = PEND_ONE;
                end
                default:
                begin
                    dec_unit = {part_reg, b[5:0]};
                    dec_part = 10'd0;
                    dec_pend = PEND_NONE;
                    dec_done = 1'b1;
                end
            endcase
        end
    end

    // Build the result and the next sequence state
    always_comb
    begin
        res_next  = '0;
        emit      = 1'b0;
        pend_next = dec_pend;
        part_next = dec_part;
        err_next  = dec_err;
        if (held_item.last_byte)
        begin
            emit                   = 1'b1;
            res_next.end_of_string = 1'b1;
            if (dec_err || (dec_pend != PEND_NONE))
            begin
                res_next.string_error = 1'b1;
            end
            else if (dec_done)
            begin
                res_next.code_unit  = dec_unit;
                res_next.unit_valid = 1'b1;
            end
            pend_next = PEND_NONE;
            part_next = 10'd0;
            err_next  = 1'b0;
        end
        else if (dec_done)
        begin
            emit                = 1'b1;
            res_next.code_unit  = dec_unit;
            res_next.unit_valid = 1'b1;
        end
    end

    // Drop the result once delivered, load a new one on a take that emits one
    assign res_valid_next = take ? emit : (res_valid_reg && !out_ready);

    // Advance the sequence state and the result valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg      <= PEND_NONE;
            part_reg      <= 10'd0;
            err_reg       <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                pend_reg <= pend_next;
                part_reg <= part_next;
                err_reg  <= err_next;
            end
            res_valid_reg <= res_valid_next;
        end
    end

    // Load the result payload
    always_ff @(posedge clk)
    begin
        if (take && emit)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid = res_valid_reg;
    assign result    = res_reg;

    // Assertions
    `U8U16_ASSERT(a_pend_range, pend_reg != 2'd3, "bytes pending out of range")
    `U8U16_ASSERT_IMPL(a_err_only_eos, res_valid_reg && !res_reg.end_of_string,
        !res_reg.string_error, "error flag on a result that is not end of string")
    `U8U16_ASSERT_IMPL(a_unit_xor_err, res_valid_reg,
        !(res_reg.unit_valid && res_reg.string_error), "unit and error both set")
    `U8U16_ASSERT_IMPL(a_empty_unit, res_valid_reg && !res_reg.unit_valid,
        res_reg.code_unit == 16'd0, "code unit not zero without a character")
    `U8U16_ASSERT_NEXT(a_eos_clears, take && held_item.last_byte,
        (pend_reg == PEND_NONE) && !err_reg, "state not cleared after end of string")

endmodule

// File: rtl/core/utf8_to_utf16_decoder.sv
// A byte is held in the input register, and its result is then registered in the
// result register, which drives the outputs until out_ready accepts it.
// Throughput: one byte per cycle while out_ready stays high; a result that
// waits for out_ready stalls decode, and the input register then holds one byte.
// Bytes that complete no character give no result transaction, unless marked last_byte.
// Reset (rst_n low, asynchronous): both registers empty, no bytes pending.
// ---------------------------------------------------------------------------
// utf8_to_utf16_decoder
// Streaming UTF-8 to UTF-16 decoder for the basic multilingual plane, with
// a sticky per-string error reported on the end-of-string result.
// ---------------------------------------------------------------------------
module utf8_to_utf16_decoder
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  in_byte,
    input  logic        last_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [15:0] code_unit,
    output logic        unit_valid,
    output logic        string_error,
    output logic        end_of_string
);
    import u8u16_pkg::*;

    in_item_t in_item;
    in_item_t held_item;
    logic     held_valid;
    logic     take;
    result_t  result;

    assign in_item.in_byte   = in_byte;
    assign in_item.last_byte = last_byte;

    // Input register
    u8u16_in_reg u_in_reg
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_item    (in_item),
        .take       (take),
        .held_valid (held_valid),
        .held_item  (held_item)
    );

    // Decode and result register
    u8u16_decode u_decode
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .held_valid (held_valid),
        .held_item  (held_item),
        .take       (take),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .result     (result)
    );

    assign code_unit     = result.code_unit;
    assign unit_valid    = result.unit_valid;
    assign string_error  = result.string_error;
    assign end_of_string = result.end_of_string;

endmodule
